[rtl/ltc_pkg.sv]
// package: types and constants for the loop trip count census
package ltc_pkg;

    localparam int unsigned FIELD_W = 48;
    localparam int unsigned NUM_THR_REGS = 6;

    localparam logic [1:0] CMD_ENTER = 2'd0;
    localparam logic [1:0] CMD_EXIT  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [4:0] SEL_ENTRIES = 5'd0;
    localparam logic [4:0] SEL_EXITS   = 5'd1;
    localparam logic [4:0] SEL_SUM     = 5'd2;
    localparam logic [4:0] SEL_ZERO    = 5'd3;
    localparam logic [4:0] SEL_MAX     = 5'd4;
    localparam logic [4:0] SEL_BUCKET0 = 5'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] loop_id;
        logic [47:0] trips;
        logic [5:0]  counter_sel;
    } t_in_item;

    typedef struct packed {
        logic [47:0] read_data;
        logic        dropped;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic clr;      // write zero rows during the clearing pass
        logic latch;    // capture item and issue memory read
        logic update;   // write back and emit result
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
    } t_sts;

endpackage

[rtl/ltc_ram.sv]
// generic ram with one write port and one registered read port
module ltc_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[rtl/ltc_ctrl.sv]
// controller: clearing pass, then a read-modify-write per item (latch and read, then write back)
module ltc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ltc_pkg::t_sts i_sts,
    output ltc_pkg::t_ctl o_ctl,
    output logic          o_busy
);
    import ltc_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_ctl.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_ctl.latch = 1'b1;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_ctl.update = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[rtl/ltc_dpath.sv]
// datapath: one wide table row per loop, update and read selection
module ltc_dpath #(
    parameter int unsigned NUM_LOOPS      = 1024,
    parameter int unsigned NUM_BUCKETS    = 12,
    parameter int unsigned NUM_THRESHOLDS = 6,
    parameter int unsigned COUNT_WIDTH    = 48
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ltc_pkg::t_ctl                           i_ctl,
    input  ltc_pkg::t_in_item                       i_item,
    input  logic [NUM_THRESHOLDS-1:0][47:0]         i_thr,
    output ltc_pkg::t_sts                           o_sts,
    output ltc_pkg::t_out_item                      o_result,
    output logic                                    o_strobe
);
    import ltc_pkg::*;

    localparam int unsigned AW = (NUM_LOOPS > 1) ? $clog2(NUM_LOOPS) : 1;
    localparam int unsigned CW = COUNT_WIDTH;
    // fields: entry, exit, sum, zero, max, buckets, atleast, atleast sums
    localparam int unsigned NF = 5 + NUM_BUCKETS + 2 * NUM_THRESHOLDS;
    localparam int unsigned FIW = (NF > 1) ? $clog2(NF) : 1;
    localparam int unsigned RW = NF * CW;
    localparam int unsigned SEL_ATL0 = 5 + NUM_BUCKETS;
    localparam int unsigned SEL_ATS0 = SEL_ATL0 + NUM_THRESHOLDS;
    localparam int unsigned SEL_LOST = SEL_ATS0 + NUM_THRESHOLDS;
    localparam int unsigned SEL_STRAY = SEL_LOST + 1;
    localparam int unsigned SEL_OVER = SEL_LOST + 2;
    localparam int unsigned SEL_SEEN = SEL_LOST + 3;
    localparam int unsigned SW = (NUM_LOOPS > 1) ? $clog2(NUM_LOOPS + 1) : 1;
    localparam logic [CW-1:0] CMAX = '1;

    t_in_item        r_item;
    logic            r_in_table;
    logic [AW-1:0]   r_clr_addr;
    logic [CW-1:0]   r_overflow;
    logic [SW-1:0]   r_seen;
    t_out_item       r_result;
    logic            r_strobe;
    logic [RW-1:0]   rd_row, wr_row;
    logic [NF-1:0][CW-1:0] f_old, f_new;
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [CW-1:0]   trips_c;
    logic [48:0]     trips_ext;
    logic [CW-1:0]   sel_val;
    logic [47:0]     rdata;
    logic            drop;
    logic [CW-1:0]   e_v, x_v;
    logic            is_exit, in_tab;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? CMAX : s[CW-1:0];
    endfunction

    assign in_tab = ({16'd0, i_item.loop_id} < 32'(NUM_LOOPS));
    assign raddr  = AW'(i_item.loop_id);

    ltc_ram #(.WIDTH(RW), .DEPTH(NUM_LOOPS)) u_tab (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wr_row),
        .i_raddr(raddr),
        .o_rdata(rd_row)
    );

    assign f_old = rd_row;
    // trips clamped to the counter width
    assign trips_ext = {1'b0, r_item.trips};
    assign trips_c = ((CW >= 48) || (trips_ext <= 49'({CMAX}))) ?
                     CW'(r_item.trips) : CMAX;
    assign is_exit = (r_item.cmd == CMD_EXIT);

    always_comb begin
        f_new = f_old;
        if (r_item.cmd == CMD_ENTER) begin
            f_new[0] = sat_add(f_old[0], CW'(1));
        end else begin
            f_new[1] = sat_add(f_old[1], CW'(1));
            f_new[2] = sat_add(f_old[2], trips_c);
            if (r_item.trips == 48'd0) begin
                f_new[3] = sat_add(f_old[3], CW'(1));
            end
            if (trips_c > f_old[4]) begin
                f_new[4] = trips_c;
            end
            for (int j = 0; j < NUM_BUCKETS; j++) begin
                if ((j == NUM_BUCKETS - 1 ||
                     {16'd0, r_item.trips} <= (64'd1 << j)) &&
                    (j == 0 || {16'd0, r_item.trips} > (64'd1 << (j - 1)))) begin
                    f_new[5 + j] = sat_add(f_old[5 + j], CW'(1));
                end
            end
            for (int j = 0; j < NUM_THRESHOLDS; j++) begin
                if (r_item.trips >= i_thr[j]) begin
                    f_new[SEL_ATL0 + j] = sat_add(f_old[SEL_ATL0 + j], CW'(1));
                    f_new[SEL_ATS0 + j] = sat_add(f_old[SEL_ATS0 + j], trips_c);
                end
            end
        end
    end

    assign we    = i_ctl.clr || (i_ctl.update && r_in_table &&
                   (r_item.cmd == CMD_ENTER || is_exit));
    assign waddr = i_ctl.clr ? r_clr_addr : AW'(r_item.loop_id);
    assign wr_row = i_ctl.clr ? '0 : f_new;
    assign o_sts.clr_last = (32'(r_clr_addr) == NUM_LOOPS - 1);

    assign e_v = f_old[0];
    assign x_v = f_old[1];

    always_comb begin
        sel_val = '0;
        if (32'(r_item.counter_sel) < NF) begin
            sel_val = f_old[FIW'(r_item.counter_sel)];
        end else if (32'(r_item.counter_sel) == SEL_LOST) begin
            sel_val = (e_v > x_v) ? e_v - x_v : '0;
        end else if (32'(r_item.counter_sel) == SEL_STRAY) begin
            sel_val = (x_v > e_v) ? x_v - e_v : '0;
        end
    end

    always_comb begin
        rdata = '0;
        drop  = 1'b0;
        if (r_item.cmd == CMD_ENTER || is_exit) begin
            drop = !r_in_table;
        end else if (r_item.cmd == CMD_READ) begin
            if (32'(r_item.counter_sel) == SEL_OVER) begin
                rdata = 48'(r_overflow);
            end else if (32'(r_item.counter_sel) == SEL_SEEN) begin
                rdata = 48'(r_seen);
            end else if (32'(r_item.counter_sel) <= SEL_STRAY) begin
                if (r_in_table) begin
                    rdata = 48'(sel_val);
                end else begin
                    drop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_item     <= i_item;
            r_in_table <= in_tab;
        end
        if (i_ctl.update) begin
            r_result.read_data <= rdata;
            r_result.dropped   <= drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_overflow <= '0;
            r_seen     <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= i_ctl.update;
            if (i_ctl.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_ctl.update && (r_item.cmd == CMD_ENTER || is_exit)) begin
                if (!r_in_table) begin
                    r_overflow <= sat_add(r_overflow, CW'(1));
                end else if (32'(r_item.loop_id) >= 32'(r_seen)) begin
                    r_seen <= SW'(32'(r_item.loop_id) + 1);
                end
            end
        end
    end

    assign o_result = r_result;
    assign o_strobe = r_strobe;
endmodule

[rtl/loop_trip_count_census_top.sv]
// top level: loop trip count census with threshold registers
// a taken start leads to write-back, then a registered result strobe
// no new item is taken until the previous one is written back (busy)
// reset clears control; a clearing pass zeroes every table row with
// busy high; thresholds return to 8,23,24,48,108,322
// results cannot be stalled by the receiver
module loop_trip_count_census_top #(
    parameter int unsigned NUM_LOOPS      = 1024,
    parameter int unsigned NUM_BUCKETS    = 12,
    parameter int unsigned NUM_THRESHOLDS = 6,
    parameter int unsigned COUNT_WIDTH    = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ltc_pkg::t_in_item  i_item,
    output logic               o_valid,
    output ltc_pkg::t_out_item o_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);
    import ltc_pkg::*;

    // threshold registers
    logic [NUM_THR_REGS-1:0][47:0]    r_thr;
    logic [NUM_THRESHOLDS-1:0][47:0]  thr;
    t_ctl ctl;
    t_sts sts;

    // config is taken only while no item is in flight or being started
    assign o_cfg_ready = !busy && !start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[0] <= 48'd8;
            r_thr[1] <= 48'd23;
            r_thr[2] <= 48'd24;
            r_thr[3] <= 48'd48;
            r_thr[4] <= 48'd108;
            r_thr[5] <= 48'd322;
        end else if (i_cfg_valid && o_cfg_ready && 32'(i_cfg_index) < NUM_THR_REGS) begin
            r_thr[i_cfg_index] <= i_cfg_data;
        end
    end

    // thresholds past the register set are fixed at zero
    always_comb begin
        for (int j = 0; j < NUM_THRESHOLDS; j++) begin
            thr[j] = (j < NUM_THR_REGS) ? r_thr[j % NUM_THR_REGS] : 48'd0;
        end
    end

    ltc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_ctl  (ctl),
        .o_busy (busy)
    );

    ltc_dpath #(
        .NUM_LOOPS     (NUM_LOOPS),
        .NUM_BUCKETS   (NUM_BUCKETS),
        .NUM_THRESHOLDS(NUM_THRESHOLDS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_item  (i_item),
        .i_thr   (thr),
        .o_sts   (sts),
        .o_result(o_item),
        .o_strobe(o_valid)
    );

    // an accepted item yields a result strobe
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("missing result strobe");

    // no two consecutive strobes
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back to back strobes");

    // only one control command at a time
    a_ctl_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(ctl))
        else $error("control commands overlap");
endmodule
